FILE: rtl/aevc_pkg.sv
// ----------------------------------------------------------------------------
// aevc_pkg
// Shared types and constants of the accelerated encoder value counter.
// ----------------------------------------------------------------------------
`default_nettype none

package aevc_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned STEP_W    = 8;
	localparam int unsigned BYTES_W   = 3;
	localparam int unsigned CFG_IDX_W = 3;

	// Tick thresholds for the acceleration steps
	localparam logic [31:0] TICK_SLOW = 32'h0000_3fff;
	localparam logic [31:0] TICK_MUL2 = 32'h0000_1fff;
	localparam logic [31:0] TICK_MUL4 = 32'h0000_0fff;
	localparam logic [31:0] TICK_MUL8 = 32'h0000_07ff;

	// Request codes
	typedef enum logic [1:0] {
		REQ_TICK = 2'd0,
		REQ_INC  = 2'd1,
		REQ_DEC  = 2'd2,
		REQ_LOAD = 2'd3
	} req_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEP_SIZE      = 3'd0,
		REG_MIN_VALUE      = 3'd1,
		REG_MAX_VALUE      = 3'd2,
		REG_DISPLAY_OFFSET = 3'd3,
		REG_NUMERIC_MODE   = 3'd4,
		REG_VALUE_BYTES    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [STEP_W-1:0]        step_size;
		logic [DATA_W-1:0]        min_value;
		logic [DATA_W-1:0]        max_value;
		logic signed [DATA_W-1:0] display_offset;
		logic                     numeric_mode;
		logic [BYTES_W-1:0]       value_bytes;
	} cfg_t;

	typedef struct packed {
		logic [DATA_W-1:0] stored_value;
		logic [DATA_W-1:0] shown_value;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/aevc_if.sv
// ----------------------------------------------------------------------------
// aevc_if
// Valid/ready channels: request items in, result items out.
// ----------------------------------------------------------------------------
`default_nettype none

interface aevc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [31:0] load_value;

	modport source (output valid, output req_type, output load_value, input ready);
	modport sink   (input valid, input req_type, input load_value, output ready);
endinterface

interface aevc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] stored_value;
	logic [31:0] shown_value;

	modport source (output valid, output stored_value, output shown_value, input ready);
	modport sink   (input valid, input stored_value, input shown_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/aevc_cfg.sv
// ----------------------------------------------------------------------------
// aevc_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module aevc_cfg
	import aevc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_wdata,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_size      <= STEP_W'(1);
			cfg_q.min_value      <= '0;
			cfg_q.max_value      <= DATA_W'(127);
			cfg_q.display_offset <= '0;
			cfg_q.numeric_mode   <= 1'b0;
			cfg_q.value_bytes    <= BYTES_W'(1);
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_STEP_SIZE:      cfg_q.step_size      <= cfg_wdata[STEP_W-1:0];
				REG_MIN_VALUE:      cfg_q.min_value      <= cfg_wdata;
				REG_MAX_VALUE:      cfg_q.max_value      <= cfg_wdata;
				REG_DISPLAY_OFFSET: cfg_q.display_offset <= $signed(cfg_wdata);
				REG_NUMERIC_MODE:   cfg_q.numeric_mode   <= cfg_wdata[0];
				REG_VALUE_BYTES:    cfg_q.value_bytes    <= cfg_wdata[BYTES_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/aevc_core.sv
// ----------------------------------------------------------------------------
// aevc_core
// Value, tick counter and wrap flag with their update logic.
// ----------------------------------------------------------------------------
`default_nettype none

module aevc_core
	import aevc_pkg::*;
#(
	parameter int unsigned TICK_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  req_t              req,
	input  logic [DATA_W-1:0] load_value,
	input  cfg_t              cfg,
	output result_t           res
);

	logic [DATA_W-1:0]     param_q;
	logic [TICK_WIDTH-1:0] tick_q;
	logic                  wrap_q;

	logic [DATA_W-1:0]     param_d;
	logic [TICK_WIDTH-1:0] tick_d;
	logic                  wrap_d;

	logic [DATA_W-1:0] mask;
	logic [DATA_W-1:0] data;
	logic [DATA_W-1:0] data_d;
	logic [31:0]       tick_ext;
	logic [STEP_W-1:0] accel;
	logic [STEP_W-1:0] step;
	logic              accel_ok;
	logic              inc_room;
	logic              dec_room;
	logic              wr;

	// value width; out-of-range byte counts clamp to 1 or 4
	always_comb begin
		case (cfg.value_bytes) inside
			3'd0, 3'd1: mask = 32'h0000_00ff;
			3'd2:       mask = 32'h0000_ffff;
			3'd3:       mask = 32'h00ff_ffff;
			default:    mask = 32'hffff_ffff;
		endcase
	end

	assign tick_ext = 32'(tick_q);
	assign data     = param_q & mask;
	assign accel_ok = !wrap_q && (tick_ext <= TICK_SLOW);

	// multiple of the step, kept to 8 bits
	always_comb begin
		if (tick_ext > TICK_MUL2)
			accel = {cfg.step_size[STEP_W-2:0], 1'b0};
		else if (tick_ext > TICK_MUL4)
			accel = {cfg.step_size[STEP_W-3:0], 2'b0};
		else if (tick_ext > TICK_MUL8)
			accel = {cfg.step_size[STEP_W-4:0], 3'b0};
		else
			accel = {cfg.step_size[STEP_W-5:0], 4'b0};
	end

	// near-bound checks, carried one bit wider so nothing wraps
	assign inc_room = ({1'b0, data} + 33'(accel) + 33'd1) < {1'b0, cfg.max_value};
	assign dec_room = ({1'b0, data} + 33'd1) > ({1'b0, cfg.min_value} + 33'(accel));

	always_comb begin
		tick_d = tick_q;
		wrap_d = wrap_q;
		data_d = data;
		step   = STEP_W'(1);
		wr     = 1'b0;
		unique case (req)
			REQ_TICK: begin
				tick_d = tick_q + TICK_WIDTH'(1);
				if (tick_d == '0)
					wrap_d = 1'b1;
			end
			REQ_LOAD: begin
				data_d = load_value;
				wr     = 1'b1;
			end
			REQ_INC: begin
				if (data < cfg.max_value) begin
					if (cfg.numeric_mode) begin
						step = cfg.step_size;
					end else begin
						if (accel_ok && inc_room)
							step = accel;
						tick_d = '0;
						wrap_d = 1'b0;
					end
					data_d = data + DATA_W'(step);
					wr     = 1'b1;
				end
			end
			REQ_DEC: begin
				if (data > cfg.min_value) begin
					if (cfg.numeric_mode) begin
						step = cfg.step_size;
					end else begin
						if (accel_ok && dec_room)
							step = accel;
						tick_d = '0;
						wrap_d = 1'b0;
					end
					data_d = data - DATA_W'(step);
					wr     = 1'b1;
				end
			end
		endcase
	end

	// upper bytes beyond the configured width keep their contents
	assign param_d = wr ? ((param_q & ~mask) | (data_d & mask)) : param_q;

	assign res.stored_value = param_d & mask;
	assign res.shown_value  = res.stored_value + $unsigned(cfg.display_offset);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			param_q <= '0;
			tick_q  <= '0;
			wrap_q  <= 1'b0;
		end else if (fire) begin
			param_q <= param_d;
			tick_q  <= tick_d;
			wrap_q  <= wrap_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/accelerated_encoder_value_counter_top.sv
// ----------------------------------------------------------------------------
// accelerated_encoder_value_counter_top
// Rotary encoder parameter counter with speed-dependent step size.
// ----------------------------------------------------------------------------
// Usage:
//  - in_ch carries request items: timer tick, increase detent, decrease
//    detent or direct load. out_ch returns one result item per request:
//    the stored value and the shown value (stored plus display offset).
//  - Config is a plain write port (cfg_wr_en, cfg_index, cfg_wdata); write
//    it only while no item is in flight.
//  - An item accepted on in_ch passes the input register, then one pass of
//    update logic into the result register, before its result shows on
//    out_ch. Throughput: one item per cycle while out_ch is not stalled; the
//    value, tick counter and wrap flag update in the same cycle, so the next item sees them.
//  - The update is one compare/add pass (core), set by the 33-bit bound
//    compare feeding the 32-bit add/subtract.
//  - Reset clears the value, tick counter and wrap flag; registers return to
//    step 1, min 0, max 127, offset 0, accelerated mode, one byte.
//  - When the receiver stalls, the result holds on out_ch and one more item
//    waits in the input register; then in_ch.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module accelerated_encoder_value_counter_top
	import aevc_pkg::*;
#(
	parameter int unsigned TICK_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	aevc_in_if.sink              in_ch,
	aevc_out_if.source           out_ch,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_wdata
);

	cfg_t    cfg;
	result_t res;

	// input register
	logic              valid_s1;
	req_t              req_s1;
	logic [DATA_W-1:0] load_s1;

	// result register
	logic              out_valid_q;
	logic [DATA_W-1:0] stored_q;
	logic [DATA_W-1:0] shown_q;

	logic advance;
	logic in_fire;

	// item in the input register moves on when the result slot is free
	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;
	assign in_fire     = in_ch.valid && in_ch.ready;

	aevc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	aevc_core #(
		.TICK_WIDTH (TICK_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (advance),
		.req        (req_s1),
		.load_value (load_s1),
		.cfg        (cfg),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_s1  <= req_t'(in_ch.req_type);
			load_s1 <= in_ch.load_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			stored_q <= res.stored_value;
			shown_q  <= res.shown_value;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.stored_value = stored_q;
	assign out_ch.shown_value  = shown_q;

endmodule

`default_nettype wire
